// ----- hw/rtl/rcde_pkg.sv -----
package rcde_pkg;

  localparam int MAX_SIGS  = 256;
  localparam int BLOCK_MAX = 32;

  localparam int SIG_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int FUNC_W  = 2;
  localparam int KIND_W  = 2;
  localparam int BSZ_W   = 6;
  localparam int SUM_W   = 16;
  localparam int IDX_W   = 8;
  localparam int ADDR_W  = (MAX_SIGS > 1) ? $clog2(MAX_SIGS) : 1;
  localparam int CNT_W   = $clog2(MAX_SIGS + 1);
  localparam int FILL_W  = $clog2(BLOCK_MAX + 1);
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RSVD  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_LIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  localparam logic REG_WIN_LEN = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_RES   = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_SPARE = 5'b10000
  } state_t;

endpackage

// ----- hw/rtl/rcde_ifs.sv -----
interface rcde_in_if;
  logic                        valid;
  logic                        ready;
  logic [rcde_pkg::FUNC_W-1:0] func;
  logic [rcde_pkg::SIG_W-1:0]  signature;
  logic [rcde_pkg::BYTE_W-1:0] data_byte;
  logic                        last_byte;
  modport source  (output valid, func, signature, data_byte, last_byte, input ready);
  modport sink    (input valid, func, signature, data_byte, last_byte, output ready);
  modport monitor (input valid, ready, func, signature, data_byte, last_byte);
endinterface

interface rcde_out_if;
  logic                        valid;
  logic                        ready;
  logic [rcde_pkg::KIND_W-1:0] token_kind;
  logic [rcde_pkg::BYTE_W-1:0] literal_value;
  logic [rcde_pkg::IDX_W-1:0]  match_index;
  logic                        last_result;
  modport source  (output valid, token_kind, literal_value, match_index, last_result,
                   input ready);
  modport sink    (input valid, token_kind, literal_value, match_index, last_result,
                   output ready);
  modport monitor (input valid, ready, token_kind, literal_value, match_index,
                   last_result);
endinterface

// ----- hw/rtl/rcde_cell.sv -----
// One window byte. Shift takes the neighbor's byte (toward the oldest end).
module rcde_cell (
  input  logic                        clk,
  input  logic                        load_en,
  input  logic [rcde_pkg::BYTE_W-1:0] load_byte,
  input  logic                        shift_en,
  input  logic [rcde_pkg::BYTE_W-1:0] nbr_byte,
  output logic [rcde_pkg::BYTE_W-1:0] byte_q
);
  logic [rcde_pkg::BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= nbr_byte;
    end else if (load_en) begin
      byte_r <= load_byte;
    end
  end

  assign byte_q = byte_r;
endmodule

// ----- hw/rtl/rolling_checksum_delta_encoder_core.sv -----
// Rolling-checksum delta encoder, sending side. Load words append 32-bit
// block signatures to a 256-entry table; data words push bytes into a window
// held in a row of byte cells. Once the window holds the configured window
// length, its weak checksum (plain sum | weighted sum << 16) is searched in
// the table one entry per cycle from index 0. A data word that fills the
// window goes from idle to the scan state, which compares table entries
// until a hit or the table's end, then to the result state, which waits
// for a free output register; words are taken only in the idle state. A
// hit emits the match index and empties the window; a miss emits the
// oldest byte as a literal and slides the cell row by one. A word marked
// last then emits one literal per remaining window byte, one per cycle
// while the output register is free, and an end token. Results leave
// through an output register, so a waiting result stalls the next step
// only when that step has a result of its own. Register 0 at address 0 is
// the window length (1..32, reset 16); writing it empties the window.
module rolling_checksum_delta_encoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  rcde_in_if.sink                       in_ch,
  rcde_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rcde_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [rcde_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [rcde_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  localparam int BM = rcde_pkg::BLOCK_MAX;
  localparam int BW = rcde_pkg::BYTE_W;
  localparam int SW = rcde_pkg::SUM_W;

  rcde_pkg::state_t state_r;

  logic [rcde_pkg::BSZ_W-1:0]   bsz_r;
  logic [rcde_pkg::CNT_W-1:0]   sig_count_r;
  logic [rcde_pkg::FILL_W-1:0]  fill_r;
  logic [SW-1:0]                plain_r, wsum_r;
  logic [2*SW-1:0]              cs_r;
  logic                         last_r;
  logic                         hit_r;
  logic [rcde_pkg::ADDR_W-1:0]  hit_idx_r;

  // table search pipeline
  logic [rcde_pkg::SIG_W-1:0]   sig_mem [rcde_pkg::MAX_SIGS];
  logic [rcde_pkg::SIG_W-1:0]   rd_data_r;
  logic [rcde_pkg::CNT_W-1:0]   scan_r;
  logic [rcde_pkg::ADDR_W-1:0]  cmp_addr_r;
  logic                         cmp_vld_r;

  // output register
  logic                         out_vld_r;
  logic [rcde_pkg::KIND_W-1:0]  out_kind_r;
  logic [BW-1:0]                out_lit_r;
  logic [rcde_pkg::IDX_W-1:0]   out_idx_r;
  logic                         out_last_r;

  // cell row
  logic [BW-1:0] cell_q [BM];
  logic          win_push, win_shift;

  logic in_acc, cfg_wr, out_free, out_load, mem_we;
  logic issue, hit, miss;
  logic [SW-1:0] plain_add, wsum_add, wt_old;
  logic [rcde_pkg::FILL_W-1:0] fill_add;
  logic [rcde_pkg::BSZ_W-1:0]  bsz_wr;

  assign in_ch.ready = (state_r == rcde_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_vld_r || out_ch.ready;
  // a new word enters the output register in these two states
  assign out_load    = out_free && ((state_r == rcde_pkg::ST_RES)
                                    || (state_r == rcde_pkg::ST_FLUSH));
  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite
                       && (cfg_paddr[2] == rcde_pkg::REG_WIN_LEN);
  assign cfg_prdata  = (cfg_paddr[2] == rcde_pkg::REG_WIN_LEN)
                       ? {{(rcde_pkg::PDATA_W-rcde_pkg::BSZ_W){1'b0}}, bsz_r}
                       : '0;

  always_comb begin
    bsz_wr = cfg_pwdata[rcde_pkg::BSZ_W-1:0];
    if (bsz_wr == '0) begin
      bsz_wr = rcde_pkg::BSZ_W'(1);
    end else if (bsz_wr > rcde_pkg::BSZ_W'(BM)) begin
      bsz_wr = rcde_pkg::BSZ_W'(BM);
    end
  end

  assign mem_we = in_acc && (in_ch.func == rcde_pkg::FUNC_LOAD)
                  && (sig_count_r < rcde_pkg::CNT_W'(rcde_pkg::MAX_SIGS));

  // running sums with the new byte
  assign plain_add = plain_r + SW'(in_ch.data_byte);
  assign wsum_add  = wsum_r + plain_add;
  assign fill_add  = fill_r + rcde_pkg::FILL_W'(1);
  // oldest byte carries weight equal to the fill
  assign wt_old    = SW'(fill_r) * SW'(cell_q[0]);

  assign issue = scan_r < sig_count_r;
  assign hit   = cmp_vld_r && (rd_data_r == cs_r);
  assign miss  = !issue && !cmp_vld_r;

  always_comb begin
    win_push  = in_acc && (in_ch.func == rcde_pkg::FUNC_DATA)
                && (fill_r < rcde_pkg::FILL_W'(BM));
    win_shift = 1'b0;
    case (state_r)
      rcde_pkg::ST_RES:   win_shift = out_free && !hit_r;
      rcde_pkg::ST_FLUSH: win_shift = out_free && (fill_r != '0);
      default:            win_shift = 1'b0;
    endcase
  end

  for (genvar i = 0; i < BM; i++) begin : g_cell
    logic [BW-1:0] nbr;
    if (i == BM - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    rcde_cell u_cell (
      .clk       (clk),
      .load_en   (win_push && (fill_r == rcde_pkg::FILL_W'(i))),
      .load_byte (in_ch.data_byte),
      .shift_en  (win_shift),
      .nbr_byte  (nbr),
      .byte_q    (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sig_mem[sig_count_r[rcde_pkg::ADDR_W-1:0]] <= in_ch.signature;
    end
    rd_data_r <= sig_mem[scan_r[rcde_pkg::ADDR_W-1:0]];
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.token_kind    = out_kind_r;
  assign out_ch.literal_value = out_lit_r;
  assign out_ch.match_index   = out_idx_r;
  assign out_ch.last_result   = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcde_pkg::ST_IDLE;
      bsz_r       <= rcde_pkg::BSZ_W'(16);
      sig_count_r <= '0;
      fill_r      <= '0;
      plain_r     <= '0;
      wsum_r      <= '0;
      out_vld_r   <= 1'b0;
      cmp_vld_r   <= 1'b0;
      scan_r      <= '0;
    end else begin
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      // the user must issue register writes only while no word is in flight; the core does not enforce it
      if (cfg_wr) begin
        bsz_r   <= bsz_wr;
        fill_r  <= '0;
        plain_r <= '0;
        wsum_r  <= '0;
      end else begin
        case (state_r)
          rcde_pkg::ST_IDLE: begin
            if (in_acc) begin
              case (in_ch.func)
                rcde_pkg::FUNC_LOAD: begin
                  if (mem_we) begin
                    sig_count_r <= sig_count_r + rcde_pkg::CNT_W'(1);
                  end
                end
                rcde_pkg::FUNC_CLEAR: begin
                  sig_count_r <= '0;
                  fill_r      <= '0;
                  plain_r     <= '0;
                  wsum_r      <= '0;
                end
                rcde_pkg::FUNC_DATA: begin
                  last_r <= in_ch.last_byte;
                  if (win_push) begin
                    fill_r  <= fill_add;
                    plain_r <= plain_add;
                    wsum_r  <= wsum_add;
                  end
                  if ((win_push ? fill_add : fill_r) >= rcde_pkg::FILL_W'(bsz_r)) begin
                    cs_r      <= win_push ? {wsum_add, plain_add} : {wsum_r, plain_r};
                    scan_r    <= '0;
                    cmp_vld_r <= 1'b0;
                    state_r   <= rcde_pkg::ST_SCAN;
                  end else if (in_ch.last_byte) begin
                    state_r <= rcde_pkg::ST_FLUSH;
                  end
                end
                default: ;
              endcase
            end
          end
          rcde_pkg::ST_SCAN: begin
            if (hit) begin
              hit_r     <= 1'b1;
              hit_idx_r <= cmp_addr_r;
              state_r   <= rcde_pkg::ST_RES;
            end else if (miss) begin
              hit_r   <= 1'b0;
              state_r <= rcde_pkg::ST_RES;
            end else begin
              cmp_vld_r  <= issue;
              cmp_addr_r <= scan_r[rcde_pkg::ADDR_W-1:0];
              if (issue) begin
                scan_r <= scan_r + rcde_pkg::CNT_W'(1);
              end
            end
          end
          rcde_pkg::ST_RES: begin
            if (out_free) begin
              out_last_r <= !last_r;
              if (hit_r) begin
                out_kind_r <= rcde_pkg::KIND_MATCH;
                out_lit_r  <= '0;
                out_idx_r  <= rcde_pkg::IDX_W'(hit_idx_r);
                fill_r     <= '0;
                plain_r    <= '0;
                wsum_r     <= '0;
              end else begin
                out_kind_r <= rcde_pkg::KIND_LIT;
                out_lit_r  <= cell_q[0];
                out_idx_r  <= '0;
                fill_r     <= fill_r - rcde_pkg::FILL_W'(1);
                plain_r    <= plain_r - SW'(cell_q[0]);
                wsum_r     <= wsum_r - wt_old;
              end
              state_r <= last_r ? rcde_pkg::ST_FLUSH : rcde_pkg::ST_IDLE;
            end
          end
          rcde_pkg::ST_FLUSH: begin
            if (out_free) begin
              out_idx_r <= '0;
              if (fill_r != '0) begin
                out_kind_r <= rcde_pkg::KIND_LIT;
                out_lit_r  <= cell_q[0];
                out_last_r <= 1'b0;
                fill_r     <= fill_r - rcde_pkg::FILL_W'(1);
              end else begin
                out_kind_r <= rcde_pkg::KIND_END;
                out_lit_r  <= '0;
                out_last_r <= 1'b1;
                plain_r    <= '0;
                wsum_r     <= '0;
                state_r    <= rcde_pkg::ST_IDLE;
              end
            end
          end
          default: state_r <= rcde_pkg::ST_IDLE;
        endcase
      end
    end
  end

endmodule

// ----- tb/sv/rcde_token_checker.sv -----
module rcde_token_checker (
  input  logic        clk,
  input  logic        rst_n,
  rcde_in_if.monitor  in_mon,
  rcde_out_if.monitor out_mon,
  input  logic        cfg_wr,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [rcde_pkg::KIND_W-1:0] kind;
    logic [rcde_pkg::BYTE_W-1:0] lit;
    logic [rcde_pkg::IDX_W-1:0]  idx;
    logic                        last;
  } token_t;

  token_t                      tok_q[$];
  logic [rcde_pkg::SIG_W-1:0]  sigs[rcde_pkg::MAX_SIGS];
  int                          nsig;
  logic [rcde_pkg::BYTE_W-1:0] win[rcde_pkg::BLOCK_MAX];
  int                          fill;
  logic [rcde_pkg::SUM_W-1:0]  psum, wsum;
  int                          bsize;

  function automatic token_t mk(logic [rcde_pkg::KIND_W-1:0] k, logic [7:0] l,
                                logic [7:0] i);
    token_t t;
    t.kind = k; t.lit = l; t.idx = i; t.last = 1'b0;
    return t;
  endfunction

  // advance the encoder model by one accepted word, queue the tokens it emits
  task automatic encode_word(logic [1:0] f, logic [31:0] s, logic [7:0] b, logic lst);
    token_t     made[$];
    logic [31:0] cs;
    int          hit;
    logic [7:0]  old;
    if (f == rcde_pkg::FUNC_LOAD) begin
      if (nsig < rcde_pkg::MAX_SIGS) begin
        sigs[nsig] = s;
        nsig++;
      end
    end else if (f == rcde_pkg::FUNC_CLEAR) begin
      nsig = 0; fill = 0; psum = '0; wsum = '0;
    end else if (f == rcde_pkg::FUNC_DATA) begin
      if (fill < rcde_pkg::BLOCK_MAX) begin
        win[fill] = b;
        fill++;
        psum = psum + b;
        wsum = wsum + psum;
      end
      if (fill >= bsize) begin
        cs = {wsum, psum};
        hit = -1;
        for (int i = 0; i < nsig; i++)
          if (hit < 0 && sigs[i] == cs) hit = i;
        if (hit >= 0) begin
          made.push_back(mk(rcde_pkg::KIND_MATCH, 8'd0, hit[7:0]));
          fill = 0; psum = '0; wsum = '0;
        end else begin
          old = win[0];
          made.push_back(mk(rcde_pkg::KIND_LIT, old, 8'd0));
          wsum = wsum - rcde_pkg::SUM_W'(fill * old);
          psum = psum - old;
          for (int i = 0; i < fill - 1; i++) win[i] = win[i+1];
          fill--;
        end
      end
      if (lst) begin
        for (int i = 0; i < fill; i++)
          made.push_back(mk(rcde_pkg::KIND_LIT, win[i], 8'd0));
        made.push_back(mk(rcde_pkg::KIND_END, 8'd0, 8'd0));
        fill = 0; psum = '0; wsum = '0;
      end
      if (made.size() > 0) made[made.size()-1].last = 1'b1;
      foreach (made[i]) tok_q.push_back(made[i]);
    end
  endtask

  always @(posedge clk) begin
    token_t exp_t, got;
    int v;
    if (!rst_n) begin
      nsig = 0; fill = 0; psum = '0; wsum = '0; bsize = 16;
      fail_count <= 0;
      tok_q.delete();
    end else begin
      if (cfg_wr) begin
        v = cfg_data[5:0];
        if (v < 1) v = 1;
        if (v > rcde_pkg::BLOCK_MAX) v = rcde_pkg::BLOCK_MAX;
        bsize = v; fill = 0; psum = '0; wsum = '0;
      end
      if (in_mon.valid && in_mon.ready)
        encode_word(in_mon.func, in_mon.signature, in_mon.data_byte, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.token_kind, out_mon.literal_value, out_mon.match_index,
               out_mon.last_result};
        if (tok_q.size() == 0) begin
          $display("%0t: unexpected token kind=%0d lit=%0h idx=%0d last=%0b", $time,
                   got.kind, got.lit, got.idx, got.last);
          fail_count <= fail_count + 1;
        end else begin
          exp_t = tok_q.pop_front();
          if (exp_t != got) begin
            $display({"%0t: token mismatch exp kind=%0d lit=%0h idx=%0d last=%0b",
                      " got kind=%0d lit=%0h idx=%0d last=%0b"},
                     $time, exp_t.kind, exp_t.lit, exp_t.idx, exp_t.last,
                     got.kind, got.lit, got.idx, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= tok_q.size();
  end
endmodule

// ----- tb/sv/tb_rolling_checksum_delta_encoder_core.sv -----
module tb_rolling_checksum_delta_encoder_core;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  rcde_in_if  in_ch ();
  rcde_out_if out_ch ();

  logic                         cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [rcde_pkg::PADDR_W-1:0] cfg_paddr = '0;
  logic [rcde_pkg::PDATA_W-1:0] cfg_pwdata = '0;
  logic [rcde_pkg::PDATA_W-1:0] cfg_prdata;
  logic                         cfg_pready;

  int  fail_count, pending;
  int  cycles = 0;
  bit  hold_long = 0;     // receiver backpressure burst request

  rolling_checksum_delta_encoder_core uut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  // register write strobe as seen by the checker
  wire cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                && cfg_paddr == rcde_pkg::PADDR_W'(0);

  rcde_token_checker chk (
    .clk, .rst_n, .in_mon(in_ch.monitor), .out_mon(out_ch.monitor),
    .cfg_wr, .cfg_data(cfg_pwdata), .fail_count, .pending
  );

  // short gaps mostly, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  // send one word; valid stays up across back-to-back words
  task automatic send_word(logic [1:0] f, logic [31:0] s, logic [7:0] b, logic lst);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      idle_cycles(g);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.signature <= s;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    idle_cycles(2);   // let the last handshake settle
  endtask

  task automatic write_bsize(logic [31:0] v);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= '0; cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // weak checksum of a block, for loading signatures that will hit
  function automatic logic [31:0] weak_sum(logic [7:0] blk[$]);
    logic [15:0] p, w;
    p = 0; w = 0;
    foreach (blk[i]) begin
      p = p + blk[i];
      w = w + p;
    end
    return {w, p};
  endfunction

  // one stream: clear, load sigs (some from real blocks), then bytes with repeats, last
  task automatic run_stream(int bsz, int nbytes, int nsig);
    logic [7:0] blk[$];
    logic [7:0] data[$];
    logic [7:0] b;
    int         st;
    send_word(rcde_pkg::FUNC_CLEAR, $urandom, 8'($urandom), 1'($urandom_range(0, 1)));
    for (int i = 0; i < nbytes; i++) data.push_back(8'($urandom));
    // repeat an earlier chunk so matches occur
    if (nbytes >= 2 * bsz)
      for (int i = 0; i < bsz; i++) data[nbytes - bsz + i] = data[i];
    for (int k = 0; k < nsig; k++) begin
      blk.delete();
      if ($urandom_range(0, 2) != 0 && nbytes >= bsz) begin
        st = $urandom_range(0, nbytes - bsz);
        for (int i = 0; i < bsz; i++) blk.push_back(data[st + i]);
        send_word(rcde_pkg::FUNC_LOAD, weak_sum(blk), 8'($urandom),
                  1'($urandom_range(0, 1)));
      end else
        send_word(rcde_pkg::FUNC_LOAD, $urandom, 8'($urandom), 1'($urandom_range(0, 1)));
    end
    for (int i = 0; i < nbytes; i++) begin
      b = data[i];
      if ($urandom_range(0, 40) == 0)
        send_word(rcde_pkg::FUNC_RSVD, $urandom, 8'($urandom), 1'b1);
      send_word(rcde_pkg::FUNC_DATA, $urandom, b, i == nbytes - 1);
    end
  endtask

  // receiver: random stalls, plus a long hold when requested
  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_long = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end else
        out_ch.ready <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.func = rcde_pkg::FUNC_LOAD; in_ch.signature = '0;
    in_ch.data_byte = '0; in_ch.last_byte = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset window length 16, extremes of fields
    send_word(rcde_pkg::FUNC_LOAD, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_word(rcde_pkg::FUNC_LOAD, 32'h0000_0000, 8'h00, 1'b0);
    send_word(rcde_pkg::FUNC_DATA, 32'hFFFF_FFFF, 8'hFF, 1'b1);    // single byte, flush
    send_word(rcde_pkg::FUNC_DATA, '0, 8'h00, 1'b0);
    send_word(rcde_pkg::FUNC_DATA, '0, 8'h80, 1'b1);
    send_word(rcde_pkg::FUNC_RSVD, 32'hA5A5_A5A5, 8'h5A, 1'b1);    // unused code
    send_word(rcde_pkg::FUNC_CLEAR, '0, '0, 1'b1);
    drain();
    write_bsize(32'd0);                                            // taken as 1
    send_word(rcde_pkg::FUNC_LOAD, 32'h0001_0001, '0, 1'b0);       // byte 1 hits
    send_word(rcde_pkg::FUNC_DATA, '0, 8'h01, 1'b0);
    send_word(rcde_pkg::FUNC_DATA, '0, 8'h02, 1'b0);
    send_word(rcde_pkg::FUNC_DATA, '0, 8'h01, 1'b1);
    drain();

    // pressure: long receiver hold while the sender keeps going
    write_bsize(32'hFFFF_FFFF);                                    // taken as 32
    hold_long = 1;
    for (int i = 0; i < 33; i++) send_word(rcde_pkg::FUNC_DATA, '0, 8'hFF, i == 32);
    drain();

    // random streams
    for (int s = 0; s < 2; s++) begin
      int bsz;
      bsz = (s == 0) ? 3 : $urandom_range(1, 8);
      write_bsize(32'(bsz));
      run_stream(bsz, $urandom_range(6, 10), $urandom_range(1, 3));
      drain();
    end

    // full table: the last entry matches, one more load is dropped
    write_bsize(32'd1);
    send_word(rcde_pkg::FUNC_CLEAR, '0, '0, 1'b0);
    for (int i = 0; i < 255; i++) send_word(rcde_pkg::FUNC_LOAD, $urandom, '0, 1'b0);
    send_word(rcde_pkg::FUNC_LOAD, 32'h0022_0022, '0, 1'b0);
    send_word(rcde_pkg::FUNC_LOAD, 32'h0033_0033, '0, 1'b0);
    send_word(rcde_pkg::FUNC_DATA, '0, 8'h22, 1'b0);
    send_word(rcde_pkg::FUNC_DATA, '0, 8'h33, 1'b1);
    drain();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
